>>> rtl/core/sacr_pkg.sv
// Shared types, constants and arithmetic helpers for the sky angle to camera rotation block.
`timescale 1ns / 1ps
package sacr_pkg;

	// Pipeline depths
	localparam int TRIG_STAGES      = 16;
	localparam int MATRIX_FRAC_BITS = 14;
	localparam int PHASE_STAGES     = 3;
	localparam int FOCAL_W          = 22;
	localparam int DIV_STEPS        = FOCAL_W;
	localparam int MAT_DLY          = DIV_STEPS - 1;
	localparam int PIPE_LEN         = PHASE_STAGES + TRIG_STAGES + 1 + 2 + DIV_STEPS;

	// Angle lanes
	localparam int LANES     = 5;
	localparam int LANE_AZ   = 0;
	localparam int LANE_ALT  = 1;
	localparam int LANE_ROLL = 2;
	localparam int LANE_HFOV = 3;
	localparam int LANE_VFOV = 4;

	// Angle to phase: 2^32 = 36000 * 119304 + 23296 = 72000 * 59652 + 23296
	localparam int TURN_HUNDREDTHS = 36000;
	localparam int PHASE_K_FULL    = 119304;
	localparam int PHASE_K_HALF    = 59652;
	localparam int PHASE_REM       = 23296;
	localparam int ROUND_FULL      = 18000;
	localparam int ROUND_HALF      = 36000;
	localparam int SHIFT_FULL      = 5;
	localparam int SHIFT_HALF      = 6;
	localparam int RECIP_DIV       = 1125;
	localparam int RECIP_MUL       = 3817748;

	// CORDIC
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic signed [31:0] EIGHTH_TURN = 32'sd536870912;

	// Matrix output scaling
	localparam int MAT_SHIFT = 30 - MATRIX_FRAC_BITS;
	localparam int MAT_RND   = (MAT_SHIFT > 0) ? (1 << (MAT_SHIFT - 1)) : 0;
	localparam logic signed [34:0] MAT_LIM = 35'sd1 <<< MATRIX_FRAC_BITS;

	// Focal divider
	localparam int NUM_W = 48;
	localparam int DEN_W = 32;
	localparam logic [FOCAL_W-1:0] FOCAL_MAX = {FOCAL_W{1'b1}};

	typedef enum logic [1:0] {
		FC_DIVIDE,
		FC_ZERO,
		FC_MAX
	} fcode_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [1:0]         quarter;
	} rot_t;

	typedef struct packed {
		logic [NUM_W-1:0]   rem;
		logic [DEN_W-1:0]   den;
		logic [FOCAL_W-1:0] quo;
		fcode_t             code;
	} div_t;

	// Arctangent of 2^-i in 2^32 turn units
	function automatic logic signed [31:0] atan_turn(input logic [4:0] idx);
		logic signed [31:0] a;
		begin
			unique case (idx)
				5'd0:  a = 32'sh20000000;
				5'd1:  a = 32'sh12E4051D;
				5'd2:  a = 32'sh09FB385B;
				5'd3:  a = 32'sh051111D4;
				5'd4:  a = 32'sh028B0D43;
				5'd5:  a = 32'sh0145D7E1;
				5'd6:  a = 32'sh00A2F61E;
				5'd7:  a = 32'sh00517C55;
				5'd8:  a = 32'sh0028BE53;
				5'd9:  a = 32'sh00145F2E;
				5'd10: a = 32'sh000A2F98;
				5'd11: a = 32'sh000517CC;
				5'd12: a = 32'sh00028BE6;
				5'd13: a = 32'sh000145F3;
				5'd14: a = 32'sh0000A2F9;
				5'd15: a = 32'sh0000517C;
				5'd16: a = 32'sh000028BE;
				5'd17: a = 32'sh0000145F;
				5'd18: a = 32'sh00000A2F;
				5'd19: a = 32'sh00000517;
				5'd20: a = 32'sh0000028B;
				5'd21: a = 32'sh00000145;
				5'd22: a = 32'sh000000A2;
				5'd23: a = 32'sh00000051;
				default: a = 32'sh00000000;
			endcase
			return a;
		end
	endfunction

	// Q30 product with round half up
	function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		begin
			p = 64'(a) * 64'(b) + 64'sd536870912;
			return p[61:30];
		end
	endfunction

	// Round Q30 to matrix format and saturate
	function automatic logic [15:0] mat_out(input logic signed [33:0] v);
		logic signed [34:0] t;
		begin
			t = (35'(v) + 35'(MAT_RND)) >>> MAT_SHIFT;
			if (t > MAT_LIM)
				t = MAT_LIM;
			else if (t < -MAT_LIM)
				t = -MAT_LIM;
			return t[15:0];
		end
	endfunction

endpackage

>>> rtl/core/sacr_phase.sv
// Angle in hundredths of a degree to 32-bit turn phase, three pipeline stages.
`timescale 1ns / 1ps
module sacr_phase (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] angle,  // reduced angle, below one turn
	input  logic        half,   // angle is a full fov, phase of its half
	output logic [31:0] phase
);

	logic [31:0] base_s1, base_s2;
	logic [25:0] w_s1, w_s2;
	logic [15:0] qe_s2;
	logic [32:0] base_full;
	logic [30:0] v;
	logic [47:0] prod;
	logic [25:0] r;
	logic        corr;

	// Split into whole part and small remainder numerator
	always_comb begin
		base_full = 33'(angle) * (half ? 33'(sacr_pkg::PHASE_K_HALF)
			: 33'(sacr_pkg::PHASE_K_FULL));
		v = 31'(angle) * 31'(sacr_pkg::PHASE_REM)
			+ (half ? 31'(sacr_pkg::ROUND_HALF) : 31'(sacr_pkg::ROUND_FULL));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_s1 <= base_full[31:0];
			w_s1    <= half ? 26'(v >> sacr_pkg::SHIFT_HALF) : 26'(v >> sacr_pkg::SHIFT_FULL);
		end
	end

	// Estimate quotient by reciprocal, low by at most one
	assign prod = 48'(w_s1) * 48'(sacr_pkg::RECIP_MUL);

	always_ff @(posedge clk) begin
		if (en) begin
			base_s2 <= base_s1;
			w_s2    <= w_s1;
			qe_s2   <= prod[47:32];
		end
	end

	// Correct estimate and add whole part
	always_comb begin
		r    = w_s2 - 26'(qe_s2) * 26'(sacr_pkg::RECIP_DIV);
		corr = (r >= 26'(sacr_pkg::RECIP_DIV));
	end

	always_ff @(posedge clk) begin
		if (en)
			phase <= base_s2 + 32'(qe_s2) + 32'(corr);
	end

endmodule

>>> rtl/core/sacr_cordic_cell.sv
// One rotation-mode CORDIC step with its output register.
`timescale 1ns / 1ps
module sacr_cordic_cell (
	input  logic            clk,
	input  logic            en,
	input  logic [4:0]      step,
	input  sacr_pkg::rot_t  rot_in,
	output sacr_pkg::rot_t  rot_out
);

	logic signed [31:0] dx, dy, da;

	always_comb begin
		dx = rot_in.y >>> step;
		dy = rot_in.x >>> step;
		da = sacr_pkg::atan_turn(step);
	end

	// Rotate toward zero residual angle
	always_ff @(posedge clk) begin
		if (en) begin
			rot_out.quarter <= rot_in.quarter;
			if (!rot_in.z[31]) begin
				rot_out.x <= rot_in.x - dx;
				rot_out.y <= rot_in.y + dy;
				rot_out.z <= rot_in.z - da;
			end else begin
				rot_out.x <= rot_in.x + dx;
				rot_out.y <= rot_in.y - dy;
				rot_out.z <= rot_in.z + da;
			end
		end
	end

endmodule

>>> rtl/core/sacr_div_cell.sv
// One restoring division step of the focal fraction with its output register.
`timescale 1ns / 1ps
module sacr_div_cell (
	input  logic           clk,
	input  logic           en,
	input  logic [4:0]     step,
	input  sacr_pkg::div_t div_in,
	output sacr_pkg::div_t div_out
);

	localparam int CMP_W = sacr_pkg::DEN_W + sacr_pkg::FOCAL_W;

	logic [CMP_W-1:0] trial;
	logic             take;

	always_comb begin
		trial = CMP_W'(div_in.den) << step;
		take  = (CMP_W'(div_in.rem) >= trial);
	end

	// Subtract shifted divisor where it fits and set the quotient bit
	always_ff @(posedge clk) begin
		if (en) begin
			div_out.den  <= div_in.den;
			div_out.code <= div_in.code;
			if (take) begin
				div_out.rem <= div_in.rem - trial[sacr_pkg::NUM_W-1:0];
				div_out.quo <= div_in.quo | (sacr_pkg::FOCAL_W'(1) << step);
			end else begin
				div_out.rem <= div_in.rem;
				div_out.quo <= div_in.quo;
			end
		end
	end

endmodule

>>> rtl/core/sky_angles_to_camera_rotation.sv
// Top level: sky pointing and fields of view to camera rotation matrix and focal fractions.
`timescale 1ns / 1ps
// Takes one pointing item per cycle while the output is not stalled and returns one
// result item per item, in order. The pipeline holds the three-stage angle to phase
// unit, a chain of TRIG_STAGES CORDIC cells per angle (five angles in parallel) and
// a chain of 22 restoring division cells for the focal fractions. The whole
// pipeline advances when the output register is empty or taken, so a stalled
// result freezes every stage and tready follows that.
// Matrix entries are signed Q1.14 saturated to +-1.0; focal fractions are
// unsigned Q6.16 saturated at the top of the range. The principal point is 0.5, 0.5.
module sky_angles_to_camera_rotation (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// azimuth[15:0], altitude[30:16], roll_angle[46:31], horizontal_fov[61:47],
	// vertical_fov[76:62], zero[79:77]
	input  logic [79:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// m00[15:0], m01[31:16], m02[47:32], m10[63:48], m11[79:64], m12[95:80],
	// m20[111:96], m21[127:112], m22[143:128], focal_x_fraction[165:144],
	// focal_y_fraction[187:166], zero[191:188]
	output logic [191:0] m_axis_tdata
);

	localparam int T = sacr_pkg::TRIG_STAGES;
	localparam int L = sacr_pkg::LANES;

	logic en;
	logic [sacr_pkg::PIPE_LEN-1:0] vld_q;
	logic out_valid_q;
	logic [191:0] out_data_q;

	logic [15:0] az;
	logic signed [14:0] alt;
	logic signed [15:0] roll;
	logic signed [16:0] alt_w, roll_w;
	logic [15:0] lane_angle [L];
	logic [31:0] lane_phase [L];
	sacr_pkg::rot_t rot [L][T+1];

	logic signed [31:0] c_s1 [L];
	logic signed [31:0] s_s1 [L];
	logic signed [31:0] c_rst [L];
	logic signed [31:0] s_rst [L];

	// Advance the pipeline when the output register is free
	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Reduce azimuth, altitude and roll to one turn; fields of view pass through
	always_comb begin
		az     = s_axis_tdata[15:0];
		alt    = s_axis_tdata[30:16];
		roll   = s_axis_tdata[46:31];
		alt_w  = 17'(alt) + (alt[14] ? 17'(sacr_pkg::TURN_HUNDREDTHS) : 17'sd0);
		roll_w = 17'(roll) + (roll[15] ? 17'(sacr_pkg::TURN_HUNDREDTHS) : 17'sd0);
		lane_angle[sacr_pkg::LANE_AZ]   = (az >= 16'(sacr_pkg::TURN_HUNDREDTHS))
			? az - 16'(sacr_pkg::TURN_HUNDREDTHS) : az;
		lane_angle[sacr_pkg::LANE_ALT]  = alt_w[15:0];
		lane_angle[sacr_pkg::LANE_ROLL] = roll_w[15:0];
		lane_angle[sacr_pkg::LANE_HFOV] = 16'(s_axis_tdata[61:47]);
		lane_angle[sacr_pkg::LANE_VFOV] = 16'(s_axis_tdata[76:62]);
	end

	// Phase unit and CORDIC chain per angle
	for (genvar g = 0; g < L; g++) begin : g_lane
		logic [31:0] shifted;

		sacr_phase u_phase (
			.clk   (clk),
			.en    (en),
			.angle (lane_angle[g]),
			.half  (g >= sacr_pkg::LANE_HFOV),
			.phase (lane_phase[g])
		);

		// Fold to nearest quarter turn
		always_comb begin
			shifted           = lane_phase[g] + 32'h20000000;
			rot[g][0].quarter = shifted[31:30];
			rot[g][0].x       = sacr_pkg::CORDIC_GAIN;
			rot[g][0].y       = 32'sd0;
			rot[g][0].z       = signed'({2'b00, shifted[29:0]}) - sacr_pkg::EIGHTH_TURN;
		end

		for (genvar i = 0; i < T; i++) begin : g_cell
			sacr_cordic_cell u_cell (
				.clk     (clk),
				.en      (en),
				.step    (5'(i)),
				.rot_in  (rot[g][i]),
				.rot_out (rot[g][i+1])
			);
		end

		// Restore the quarter
		always_comb begin
			case (rot[g][T].quarter)
				2'd0: begin
					c_rst[g] = rot[g][T].x;
					s_rst[g] = rot[g][T].y;
				end
				2'd1: begin
					c_rst[g] = -rot[g][T].y;
					s_rst[g] = rot[g][T].x;
				end
				2'd2: begin
					c_rst[g] = -rot[g][T].x;
					s_rst[g] = -rot[g][T].y;
				end
				default: begin
					c_rst[g] = rot[g][T].y;
					s_rst[g] = -rot[g][T].x;
				end
			endcase
		end

		always_ff @(posedge clk) begin
			if (en) begin
				c_s1[g] <= c_rst[g];
				s_s1[g] <= s_rst[g];
			end
		end
	end

	// Basis vectors: forward and up products, right from azimuth
	logic signed [31:0] f0_s2, f1_s2, f2_s2, u0_s2, u1_s2, u2_s2, r0_s2, r2_s2;
	logic signed [31:0] cr_s2, sr_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			f0_s2 <= sacr_pkg::mul_q30(c_s1[sacr_pkg::LANE_ALT], s_s1[sacr_pkg::LANE_AZ]);
			f1_s2 <= s_s1[sacr_pkg::LANE_ALT];
			f2_s2 <= sacr_pkg::mul_q30(c_s1[sacr_pkg::LANE_ALT], c_s1[sacr_pkg::LANE_AZ]);
			u0_s2 <= -sacr_pkg::mul_q30(s_s1[sacr_pkg::LANE_ALT], s_s1[sacr_pkg::LANE_AZ]);
			u1_s2 <= c_s1[sacr_pkg::LANE_ALT];
			u2_s2 <= -sacr_pkg::mul_q30(s_s1[sacr_pkg::LANE_ALT], c_s1[sacr_pkg::LANE_AZ]);
			r0_s2 <= c_s1[sacr_pkg::LANE_AZ];
			r2_s2 <= -s_s1[sacr_pkg::LANE_AZ];
			cr_s2 <= c_s1[sacr_pkg::LANE_ROLL];
			sr_s2 <= s_s1[sacr_pkg::LANE_ROLL];
		end
	end

	// Roll products
	logic signed [31:0] a_s3 [3];
	logic signed [31:0] b_s3 [3];
	logic signed [31:0] c_s3 [3];
	logic signed [31:0] d_s3 [3];
	logic signed [31:0] fw_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3[0]  <= sacr_pkg::mul_q30(r0_s2, cr_s2);
			b_s3[0]  <= sacr_pkg::mul_q30(u0_s2, sr_s2);
			c_s3[0]  <= sacr_pkg::mul_q30(r0_s2, sr_s2);
			d_s3[0]  <= sacr_pkg::mul_q30(u0_s2, cr_s2);
			a_s3[1]  <= 32'sd0;
			b_s3[1]  <= sacr_pkg::mul_q30(u1_s2, sr_s2);
			c_s3[1]  <= 32'sd0;
			d_s3[1]  <= sacr_pkg::mul_q30(u1_s2, cr_s2);
			a_s3[2]  <= sacr_pkg::mul_q30(r2_s2, cr_s2);
			b_s3[2]  <= sacr_pkg::mul_q30(u2_s2, sr_s2);
			c_s3[2]  <= sacr_pkg::mul_q30(r2_s2, sr_s2);
			d_s3[2]  <= sacr_pkg::mul_q30(u2_s2, cr_s2);
			fw_s3[0] <= f0_s2;
			fw_s3[1] <= f1_s2;
			fw_s3[2] <= f2_s2;
		end
	end

	// Combine, round and saturate the matrix
	logic [143:0] mat_s4;
	logic [143:0] mat_line [sacr_pkg::MAT_DLY];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				mat_s4[k*48 +: 16]      <= sacr_pkg::mat_out(34'(a_s3[k]) + 34'(b_s3[k]));
				mat_s4[k*48 + 16 +: 16] <= sacr_pkg::mat_out(34'(c_s3[k]) - 34'(d_s3[k]));
				mat_s4[k*48 + 32 +: 16] <= sacr_pkg::mat_out(34'(fw_s3[k]));
			end
		end
	end

	// Hold the matrix until the focal fractions catch up
	always_ff @(posedge clk) begin
		if (en) begin
			mat_line[0] <= mat_s4;
			for (int k = 1; k < sacr_pkg::MAT_DLY; k++)
				mat_line[k] <= mat_line[k-1];
		end
	end

	// Focal fraction: numerator, divisor, special cases, then division chain
	logic [sacr_pkg::FOCAL_W-1:0] focal [2];

	for (genvar f = 0; f < 2; f++) begin : g_focal
		logic [sacr_pkg::NUM_W-1:0] num_s2;
		logic [sacr_pkg::DEN_W-1:0] den_s2;
		logic                       cneg_s2, sneg_s2;
		logic                       sat;
		sacr_pkg::div_t             dv [sacr_pkg::DIV_STEPS+1];
		sacr_pkg::div_t             dv_s3;

		always_ff @(posedge clk) begin
			if (en) begin
				num_s2  <= (sacr_pkg::NUM_W'(c_s1[sacr_pkg::LANE_HFOV + f]) << 16)
					+ sacr_pkg::NUM_W'(s_s1[sacr_pkg::LANE_HFOV + f]);
				den_s2  <= s_s1[sacr_pkg::LANE_HFOV + f] << 1;
				cneg_s2 <= (c_s1[sacr_pkg::LANE_HFOV + f] <= 32'sd0);
				sneg_s2 <= (s_s1[sacr_pkg::LANE_HFOV + f] <= 32'sd0);
			end
		end

		// Quotient overflows the output range
		assign sat = ((sacr_pkg::DEN_W + sacr_pkg::FOCAL_W)'(num_s2)
			>= ((sacr_pkg::DEN_W + sacr_pkg::FOCAL_W)'(den_s2) << sacr_pkg::FOCAL_W));

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s3.rem <= num_s2;
				dv_s3.den <= den_s2;
				dv_s3.quo <= '0;
				if (cneg_s2)
					dv_s3.code <= sacr_pkg::FC_ZERO;
				else if (sneg_s2 || sat)
					dv_s3.code <= sacr_pkg::FC_MAX;
				else
					dv_s3.code <= sacr_pkg::FC_DIVIDE;
			end
		end

		assign dv[0] = dv_s3;

		for (genvar i = 0; i < sacr_pkg::DIV_STEPS; i++) begin : g_step
			sacr_div_cell u_div (
				.clk     (clk),
				.en      (en),
				.step    (5'(sacr_pkg::DIV_STEPS - 1 - i)),
				.div_in  (dv[i]),
				.div_out (dv[i+1])
			);
		end

		// Pick the special value or the quotient
		always_comb begin
			case (dv[sacr_pkg::DIV_STEPS].code)
				sacr_pkg::FC_ZERO: focal[f] = '0;
				sacr_pkg::FC_MAX:  focal[f] = sacr_pkg::FOCAL_MAX;
				default:           focal[f] = dv[sacr_pkg::DIV_STEPS].quo;
			endcase
		end
	end

	// Output register and valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[sacr_pkg::PIPE_LEN-2:0], s_axis_tvalid};
			out_valid_q <= vld_q[sacr_pkg::PIPE_LEN-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			out_data_q <= {4'b0, focal[1], focal[0], mat_line[sacr_pkg::MAT_DLY-1]};
	end

endmodule
